/* hw/rtl/gdn_pkg.sv */
// ---------------------------------------------------------------------------
// gdn_pkg
// Shared widths, constants, types and the month start table of the
// Gregorian day number converter.
// ---------------------------------------------------------------------------
package gdn_pkg;

  // field widths
  localparam int YEAR_W     = 17;
  localparam int MONTH_W    = 4;
  localparam int MDAY_W     = 5;
  localparam int DAYS_W     = 26;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // pipeline depth from accepted word to the output buffer
  localparam int PIPE_DEPTH = 10;
  // stages that do real work in the date to day number path
  localparam int C2D_STAGES = 4;

  // operation codes carried in tuser
  localparam logic OP_DATE_TO_DAYS = 1'b0;
  localparam logic OP_DAYS_TO_DATE = 1'b1;

  // date to day number: year biased by 165 eras so all quotients are unsigned
  localparam logic [17:0] YEAR_BIAS   = 18'd66000;
  // 365*bias + bias/4 - bias/100 + bias/400 + days from 0000-03-01 to epoch
  localparam logic [25:0] C2D_OFFSET  = 26'd24825473;
  // x/25 = (x*5243)>>17, exact for x below 43690
  localparam logic [12:0] DIV25_RECIP = 13'd5243;

  // day number to date: bias of 225 eras plus the epoch offset
  localparam logic [26:0] DAY_BIAS        = 27'd33591293;
  localparam int          ERA_DAYS        = 146097;
  localparam int          ERA_RECIP       = 235183;
  localparam int          ERA_SHIFT       = 35;
  localparam int          DOE_LAST        = 146096;
  localparam int          DAYS_4Y         = 1460;
  localparam int          RECIP_4Y        = 11491;
  localparam int          DAYS_100Y       = 36524;
  localparam int          RECIP_100Y      = 459;
  localparam int          DAYS_1Y         = 365;
  localparam int          RECIP_1Y        = 45964;
  localparam int          RECIP_SHIFT     = 24;
  localparam int          ERA_BIAS_YEARS  = 90000;
  // first day of March-based month ten (January)
  localparam logic [8:0]  JAN_START       = 9'd306;

  // result of the day number to date path
  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [MDAY_W-1:0]        mday;
    logic                     range_err;
  } civil_t;

  // one result word
  typedef struct packed {
    logic signed [DAYS_W-1:0] days;
    civil_t                   civil;
  } result_t;

  // day of the March-based year on which month mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      4'd12:   s = 9'd367;
      4'd13:   s = 9'd398;
      4'd14:   s = 9'd428;
      4'd15:   s = 9'd459;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/gdn_date_to_days.sv */
// ---------------------------------------------------------------------------
// gdn_date_to_days
// Pipelined date to day number path: biased March-based year, constant
// reciprocal divisions, final sum, then delay stages to the common depth.
// ---------------------------------------------------------------------------
module gdn_date_to_days (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [gdn_pkg::YEAR_W-1:0] year,
  input  logic [gdn_pkg::MONTH_W-1:0]       month,
  input  logic [gdn_pkg::MDAY_W-1:0]        day_of_month,
  output logic signed [gdn_pkg::DAYS_W-1:0] days
);
  import gdn_pkg::*;

  localparam int PAD = PIPE_DEPTH - C2D_STAGES;

  logic             leap_adj;
  logic [3:0]       mp_c;
  logic [17:0]      yb_c;
  logic [9:0]       doy_c;

  logic [17:0]      c1_yb;
  logic [9:0]       c1_doy;
  logic [28:0]      c2_pa;
  logic [28:0]      c2_pb;
  logic [26:0]      c2_p365;
  logic [15:0]      c2_y4;
  logic [9:0]       c2_doy;
  logic [DAYS_W-1:0] c3_sa;
  logic [DAYS_W-1:0] c3_sb;
  logic [DAYS_W-1:0] c4_days;
  logic [DAYS_W-1:0] pad_q [PAD];

  // stage 1: March-based year, biased, and day of year
  always_comb begin
    leap_adj = (month < 4'd3);
    mp_c     = leap_adj ? month + 4'd9 : month - 4'd3;
    yb_c     = {year[YEAR_W-1], year} + YEAR_BIAS - {17'd0, leap_adj};
    doy_c    = {1'b0, month_start(mp_c)} + {5'd0, day_of_month} - 10'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_yb  <= yb_c;
      c1_doy <= doy_c;
    end
  end

  // stage 2: reciprocal products for /100 and /400, and 365*year
  always_ff @(posedge clk) begin
    if (en) begin
      c2_pa   <= 29'(c1_yb[17:2]) * 29'(DIV25_RECIP);
      c2_pb   <= 29'(c1_yb[17:4]) * 29'(DIV25_RECIP);
      c2_p365 <= 27'(c1_yb) * 27'(DAYS_1Y);
      c2_y4   <= c1_yb[17:2];
      c2_doy  <= c1_doy;
    end
  end

  // stage 3: partial sums, modulo the day field width
  always_ff @(posedge clk) begin
    if (en) begin
      c3_sa <= DAYS_W'(c2_p365) + DAYS_W'(c2_y4) + {{(DAYS_W-10){c2_doy[9]}}, c2_doy};
      c3_sb <= DAYS_W'(c2_pb[28:17]) - DAYS_W'(c2_pa[28:17]);
    end
  end

  // stage 4: remove the bias and epoch offset
  always_ff @(posedge clk) begin
    if (en) begin
      c4_days <= c3_sa + c3_sb - C2D_OFFSET;
    end
  end

  // delay to match the day number to date path
  always_ff @(posedge clk) begin
    if (en) begin
      pad_q[0] <= c4_days;
      for (int i = 1; i < PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
  end

  assign days = $signed(pad_q[PAD-1]);

endmodule

/* hw/rtl/gdn_days_to_date.sv */
// ---------------------------------------------------------------------------
// gdn_days_to_date
// Ten-stage day number to date path: era split, year of era via constant
// reciprocals with one correction step each, then month, day and year.
// ---------------------------------------------------------------------------
module gdn_days_to_date (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [gdn_pkg::DAYS_W-1:0] day_count,
  output gdn_pkg::civil_t                   civil
);
  import gdn_pkg::*;

  // stage registers
  logic [26:0] d1_u;
  logic [26:0] d2_u;
  logic [43:0] d2_prod;
  logic [8:0]  d3_era;
  logic [17:0] d3_doe;
  logic [31:0] d4_p1;
  logic [26:0] d4_p2;
  logic [8:0]  d4_era;
  logic [17:0] d4_doe;
  logic [6:0]  d5_q1;
  logic [2:0]  d5_q2;
  logic        d5_q3;
  logic [8:0]  d5_era;
  logic [17:0] d5_doe;
  logic [17:0] d6_t;
  logic [8:0]  d6_era;
  logic [17:0] d6_doe;
  logic [33:0] d7_p;
  logic [17:0] d7_t;
  logic [8:0]  d7_era;
  logic [17:0] d7_doe;
  logic [8:0]  d8_yoe;
  logic [8:0]  d8_era;
  logic [17:0] d8_doe;
  logic [8:0]  d9_doy;
  logic [18:0] d9_yb;
  civil_t      d10_civil;

  // combinational helpers
  logic [8:0]  era_est;
  logic [26:0] era_rem;
  logic        era_fix;
  logic [6:0]  e1;
  logic [2:0]  e2;
  logic [17:0] nxt1;
  logic [17:0] nxt2;
  logic [8:0]  yoe_est;
  logic [17:0] nxt_y;
  logic [1:0]  hund;
  logic [17:0] doy_base;
  logic [3:0]  mp;
  logic [18:0] yr;
  civil_t      civil_c;

  // stage 1: shift to a nonnegative count
  always_ff @(posedge clk) begin
    if (en) begin
      d1_u <= {day_count[DAYS_W-1], day_count} + DAY_BIAS;
    end
  end

  // stage 2: era reciprocal product
  always_ff @(posedge clk) begin
    if (en) begin
      d2_prod <= 44'(d1_u) * 44'(ERA_RECIP);
      d2_u    <= d1_u;
    end
  end

  // stage 3: era and day of era, estimate corrected by one
  always_comb begin
    era_est = d2_prod[ERA_SHIFT+8:ERA_SHIFT];
    era_rem = d2_u - 27'(era_est) * 27'(ERA_DAYS);
    era_fix = (era_rem >= 27'(ERA_DAYS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_era <= era_est + {8'd0, era_fix};
      d3_doe <= era_fix ? 18'(era_rem - 27'(ERA_DAYS)) : 18'(era_rem);
    end
  end

  // stage 4: reciprocal products for /1460 and /36524
  always_ff @(posedge clk) begin
    if (en) begin
      d4_p1  <= 32'(d3_doe) * 32'(RECIP_4Y);
      d4_p2  <= 27'(d3_doe) * 27'(RECIP_100Y);
      d4_era <= d3_era;
      d4_doe <= d3_doe;
    end
  end

  // stage 5: correct the quotients, flag the last day of the era
  always_comb begin
    e1   = d4_p1[RECIP_SHIFT+6:RECIP_SHIFT];
    e2   = d4_p2[RECIP_SHIFT+2:RECIP_SHIFT];
    nxt1 = 18'(e1) * 18'(DAYS_4Y) + 18'(DAYS_4Y);
    nxt2 = 18'(e2) * 18'(DAYS_100Y) + 18'(DAYS_100Y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_q1  <= e1 + {6'd0, (d4_doe >= nxt1)};
      d5_q2  <= e2 + {2'd0, (d4_doe >= nxt2)};
      d5_q3  <= (d4_doe == 18'(DOE_LAST));
      d5_era <= d4_era;
      d5_doe <= d4_doe;
    end
  end

  // stage 6: day of era with leap days removed
  always_ff @(posedge clk) begin
    if (en) begin
      d6_t   <= d5_doe - 18'(d5_q1) + 18'(d5_q2) - 18'(d5_q3);
      d6_era <= d5_era;
      d6_doe <= d5_doe;
    end
  end

  // stage 7: reciprocal product for /365
  always_ff @(posedge clk) begin
    if (en) begin
      d7_p   <= 34'(d6_t) * 34'(RECIP_1Y);
      d7_t   <= d6_t;
      d7_era <= d6_era;
      d7_doe <= d6_doe;
    end
  end

  // stage 8: year of era
  always_comb begin
    yoe_est = d7_p[RECIP_SHIFT+8:RECIP_SHIFT];
    nxt_y   = 18'(yoe_est) * 18'(DAYS_1Y) + 18'(DAYS_1Y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d8_yoe <= yoe_est + {8'd0, (d7_t >= nxt_y)};
      d8_era <= d7_era;
      d8_doe <= d7_doe;
    end
  end

  // stage 9: day of year and March-based year
  always_comb begin
    hund     = 2'(d8_yoe >= 9'd100) + 2'(d8_yoe >= 9'd200) + 2'(d8_yoe >= 9'd300);
    doy_base = 18'(d8_yoe) * 18'(DAYS_1Y) + 18'(d8_yoe[8:2]) - 18'(hund);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d9_doy <= 9'(d8_doe - doy_base);
      d9_yb  <= 19'(d8_yoe) + 19'(d8_era) * 19'(400) - 19'(ERA_BIAS_YEARS);
    end
  end

  // stage 10: month, day, civil year and range check
  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(d9_doy >= month_start(4'(k)));
    end
    yr      = d9_yb + 19'(d9_doy >= JAN_START);
    civil_c = '0;
    if ((yr[18:16] == 3'b000) || (yr[18:16] == 3'b111)) begin
      civil_c.year  = $signed(yr[YEAR_W-1:0]);
      civil_c.month = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      civil_c.mday  = 5'(d9_doy - month_start(mp) + 9'd1);
    end else begin
      civil_c.range_err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d10_civil <= civil_c;
    end
  end

  assign civil = d10_civil;

endmodule

/* hw/rtl/gdn_out_buf.sv */
// ---------------------------------------------------------------------------
// gdn_out_buf
// Two-entry output buffer. Its ready comes from registered state only, so
// the downstream tready never reaches the input side combinationally.
// ---------------------------------------------------------------------------
module gdn_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gdn_pkg::result_t in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output gdn_pkg::result_t out_word
);
  import gdn_pkg::*;

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       push;
  logic       pop;
  result_t    slot0;
  result_t    slot1;

  // handshake and fill count
  always_comb begin
    in_ready  = (cnt != 2'd2);
    out_valid = (cnt != 2'd0);
    push      = in_valid && in_ready;
    pop       = out_valid && out_ready;
    cnt_next  = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // slot0 is the head word
  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= in_word;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= in_word;
      end else begin
        slot1 <= in_word;
      end
    end
  end

  assign out_word = slot0;

endmodule

/* hw/rtl/gregorian_day_number_converter.sv */
// ---------------------------------------------------------------------------
// gregorian_day_number_converter
// Converts between proleptic Gregorian dates and signed day numbers from
// 1970-01-01, one word per clock while m_axis_tready is high.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser selects the operation (0: date to day
//   number, 1: day number to date), tdata carries year, month, day of month
//   and day number; unused fields are ignored.
//   Output stream m_axis: tdata carries day number, year, month and day of
//   month; fields of the other operation are zero. tuser flags a year that
//   does not fit 17 bits, in which case all of tdata is zero.
//   Throughput: one word per cycle, sustained, in both directions, while
//   m_axis_tready is high. The word passes ten pipeline stages, the first
//   loaded at acceptance, then the output buffer. Both paths are padded
//   to the day number to date chain.
//   Stall: results land in a two-entry output buffer; when it is full the
//   whole pipeline freezes and s_axis_tready goes low, nothing is lost.
//   s_axis_tready depends only on registered state and rst.
//   Reset: synchronous rst clears the pipeline valid bits and the output
//   buffer; the block accepts words from the first cycle after reset.
// ---------------------------------------------------------------------------
module gregorian_day_number_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // year[16:0], month[20:17], day_of_month[25:21], day_count[51:26], zero fill
  input  logic [gdn_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // op[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // day_count_out[25:0], year_out[42:26], month_out[46:43], mday_out[51:47],
  // zero fill
  output logic [gdn_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // range_error[0]
  output logic                                m_axis_tuser
);
  import gdn_pkg::*;

  logic                     en;
  logic [PIPE_DEPTH-1:0]    vld;
  logic [PIPE_DEPTH-1:0]    op_q;
  logic signed [YEAR_W-1:0] in_year;
  logic [MONTH_W-1:0]       in_month;
  logic [MDAY_W-1:0]        in_mday;
  logic signed [DAYS_W-1:0] in_days;
  logic signed [DAYS_W-1:0] c2d_days;
  civil_t                   d2c_civil;
  result_t                  res;
  result_t                  out_word;

  // unpack the input word
  assign in_year  = $signed(s_axis_tdata[16:0]);
  assign in_month = s_axis_tdata[20:17];
  assign in_mday  = s_axis_tdata[25:21];
  assign in_days  = $signed(s_axis_tdata[51:26]);

  // no word is taken while reset is held
  assign s_axis_tready = en && !rst;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_q <= {op_q[PIPE_DEPTH-2:0], s_axis_tuser};
    end
  end

  gdn_date_to_days u_c2d (
    .clk          (clk),
    .en           (en),
    .year         (in_year),
    .month        (in_month),
    .day_of_month (in_mday),
    .days         (c2d_days)
  );

  gdn_days_to_date u_d2c (
    .clk       (clk),
    .en        (en),
    .day_count (in_days),
    .civil     (d2c_civil)
  );

  // pick the result of the requested operation
  always_comb begin
    res = '0;
    if (op_q[PIPE_DEPTH-1] == OP_DAYS_TO_DATE) begin
      res.civil = d2c_civil;
    end else begin
      res.days = c2d_days;
    end
  end

  gdn_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[PIPE_DEPTH-1]),
    .in_ready  (en),
    .in_word   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  // pack the output word
  assign m_axis_tdata = {4'd0, out_word.civil.mday, out_word.civil.month,
                         out_word.civil.year, out_word.days};
  assign m_axis_tuser = out_word.civil.range_err;

endmodule

/* hw/rtl/gdn_checker.sv */
// ---------------------------------------------------------------------------
// gdn_checker
// Port-level assertions for the Gregorian day number converter, bound to
// the top level.
// ---------------------------------------------------------------------------
module gdn_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gdn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import gdn_pkg::*;

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // reset empties the output buffer
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // an empty output buffer always takes input
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // out of range year clears every field
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("range error with nonzero fields");

  // a converted date has a real month and a nonzero day
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[46:43] != 4'd0) |->
      (m_axis_tdata[46:43] <= 4'd12) && (m_axis_tdata[51:47] != 5'd0))
    else $error("month or day out of range");

endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
